>>> rtl/core/bmss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmss_pkg
// Shared widths, codes and types of the block-matching SSD search with
// sub-pixel quadratic peak refinement.
// ----------------------------------------------------------------------------
package bmss_pkg;

    localparam int DEF_MAX_DEPTH       = 256;
    localparam int DEF_MAX_HALF_WINDOW = 15;
    localparam int DEF_SAMPLE_BITS     = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_COUNT = 2'd1;

    localparam logic [3:0] HALF_WINDOW_RESET = 4'd2;
    localparam logic [8:0] COEFF_COUNT_RESET = 9'd64;

    // Stream command codes carried on tuser.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_REF   = 1'b1;

    localparam int SSD_W   = 41;
    localparam int SCORE_W = 42;
    localparam int PEAK_W  = 41;
    localparam int DISP_W  = 17;

    localparam logic [SSD_W-1:0] SSD_LIMIT = {1'b1, {(SSD_W-1){1'b0}}};

    // Fit datapath widths.
    localparam int FIT_BITS = 22;
    localparam int D_W      = SCORE_W + 1;
    localparam int SD_W     = FIT_BITS + 1;
    localparam int S_W      = 6;
    localparam int G_W      = 25;
    localparam int P_W      = 2 * G_W;
    localparam int N_W      = 54;
    localparam int DV_W     = 64;
    localparam int DS_W     = 56;
    localparam int IT_W     = 7;
    localparam int Q_W      = 17;
    localparam int SUM_W    = 20;
    localparam int OFF_W    = 16;

    localparam logic [Q_W-1:0] Q_SAT = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic                    done;
        logic signed [OFF_W-1:0] off_y;
        logic signed [OFF_W-1:0] off_x;
    } t_fit_res;

endpackage
`default_nettype wire

>>> rtl/core/bmss_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmss_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bmss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/core/bmss_fit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmss_fit
// Sequenced sub-pixel refinement: locates the peak row and column, reads the
// 3x3 neighborhood, normalizes, forms the quadratic terms on one shared
// multiplier and divides on one shared bit-serial divider.
// ----------------------------------------------------------------------------
module bmss_fit
    import bmss_pkg::*;
#(
    parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
    parameter int HW_W  = $clog2(MAX_HALF_WINDOW + 1),
    parameter int SIDE  = 2 * MAX_HALF_WINDOW + 1,
    parameter int SA_W  = $clog2(SIDE * SIDE),
    parameter int POS_W = $clog2(SIDE * SIDE + 1)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [POS_W-1:0]          i_best_index,
    input  wire logic [HW_W-1:0]           i_hw,
    output logic      [SA_W-1:0]           o_raddr,
    input  wire logic signed [SCORE_W-1:0] i_rdata,
    output t_fit_res                       o_res
);

    typedef enum logic [10:0] {
        F_IDLE = 11'b00000000001,
        F_POS  = 11'b00000000010,
        F_RD   = 11'b00000000100,
        F_NORM = 11'b00000001000,
        F_SCL  = 11'b00000010000,
        F_MUL  = 11'b00000100000,
        F_NUM  = 11'b00001000000,
        F_DSET = 11'b00010000000,
        F_DIV  = 11'b00100000000,
        F_DFIN = 11'b01000000000,
        F_OFF  = 11'b10000000000
    } t_fstate;

    localparam int WW_W = 2 * (HW_W + 1);
    localparam int CO_W = HW_W + 3;

    // Neighbor order: center, up, down, left, right, down-right, down-left,
    // up-right, up-left.
    function automatic logic signed [1:0] nb_dy(input logic [3:0] k);
        logic signed [1:0] v;
        unique case (k)
            4'd1, 4'd7, 4'd8: v = -2'sd1;
            4'd2, 4'd5, 4'd6: v = 2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] nb_dx(input logic [3:0] k);
        logic signed [1:0] v;
        unique case (k)
            4'd3, 4'd6, 4'd8: v = -2'sd1;
            4'd4, 4'd5, 4'd7: v = 2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

    t_fstate r_state;
    logic [POS_W-1:0]          r_rem_idx;
    logic [POS_W-1:0]          r_by;
    logic [HW_W:0]             r_byc;
    logic [HW_W:0]             r_bx;
    logic [HW_W-1:0]           r_hw;
    logic [3:0]                r_k;
    logic [2:0]                r_i;
    logic signed [SCORE_W-1:0] r_c0;
    logic signed [D_W-1:0]     r_d  [8];
    logic signed [SD_W-1:0]    r_ds [8];
    logic [D_W-1:0]            r_m;
    logic [S_W-1:0]            r_s;
    logic signed [P_W-1:0]     r_p  [6];
    logic signed [N_W-1:0]     r_den, r_ny, r_nx;
    logic                      r_j;
    logic                      r_neg;
    logic [DV_W-1:0]           r_quo;
    logic [DS_W-1:0]           r_rem;
    logic [DS_W-1:0]           r_dvs;
    logic [IT_W-1:0]           r_it;
    logic signed [Q_W:0]       r_qy, r_qx;
    logic                      r_done;
    logic signed [OFF_W-1:0]   r_off_y, r_off_x;

    logic [HW_W:0]          w;
    logic [HW_W:0]          lim2;
    logic signed [CO_W-1:0] row_s, col_s;
    logic [HW_W:0]          row_c, col_c;
    logic [WW_W:0]          addr_full;
    logic signed [D_W-1:0]  dnew;
    logic [D_W-1:0]         dnew_mag;
    logic [3:0]             km2;
    logic signed [D_W-1:0]  dsel;
    logic [D_W-1:0]         dsel_mag, dsel_sh;
    logic signed [G_W-1:0]  gy, dyy, gx, dxx, dd;
    logic signed [G_W-1:0]  ma, mb;
    logic signed [P_W-1:0]  mp;
    logic signed [N_W-1:0]  nsel;
    logic [N_W-1:0]         n_mag, den_mag;
    logic [DS_W:0]          rem_sh;
    logic                   ge;
    logic [Q_W-1:0]         q_sat;
    logic signed [Q_W:0]    q_val;
    logic signed [HW_W+1:0] base_y, base_x;
    logic signed [SUM_W-1:0] sum_y, sum_x, lim_off;
    logic signed [SUM_W-1:0] cl_y, cl_x;

    assign w    = {r_hw, 1'b1};
    assign lim2 = {r_hw, 1'b0};

    // Clamped neighbor address.
    always_comb begin
        row_s = $signed({2'b00, r_byc}) + CO_W'(nb_dy(r_k));
        col_s = $signed({2'b00, r_bx})  + CO_W'(nb_dx(r_k));
        if (row_s < 0) begin
            row_c = '0;
        end else if (row_s > $signed({2'b00, lim2})) begin
            row_c = lim2;
        end else begin
            row_c = row_s[HW_W:0];
        end
        if (col_s < 0) begin
            col_c = '0;
        end else if (col_s > $signed({2'b00, lim2})) begin
            col_c = lim2;
        end else begin
            col_c = col_s[HW_W:0];
        end
        addr_full = (WW_W + 1)'(row_c * w) + (WW_W + 1)'(col_c);
    end

    assign o_raddr = addr_full[SA_W-1:0];

    assign dnew     = D_W'(i_rdata) - D_W'(r_c0);
    assign dnew_mag = dnew[D_W-1] ? D_W'(-dnew) : D_W'(dnew);
    assign km2      = r_k - 4'd2;

    assign dsel     = r_d[r_i];
    assign dsel_mag = dsel[D_W-1] ? D_W'(-dsel) : D_W'(dsel);
    assign dsel_sh  = dsel_mag >> r_s;

    assign gy  = G_W'(r_ds[1]) - G_W'(r_ds[0]);
    assign dyy = G_W'(r_ds[1]) + G_W'(r_ds[0]);
    assign gx  = G_W'(r_ds[3]) - G_W'(r_ds[2]);
    assign dxx = G_W'(r_ds[3]) + G_W'(r_ds[2]);
    assign dd  = G_W'(r_ds[4]) - G_W'(r_ds[5]) - G_W'(r_ds[6]) + G_W'(r_ds[7]);

    always_comb begin
        unique case (r_k)
            4'd0:    begin ma = dxx; mb = dyy; end
            4'd1:    begin ma = dd;  mb = dd;  end
            4'd2:    begin ma = dxx; mb = gy;  end
            4'd3:    begin ma = dd;  mb = gx;  end
            4'd4:    begin ma = dyy; mb = gx;  end
            default: begin ma = dd;  mb = gy;  end
        endcase
    end

    assign mp = ma * mb;

    assign nsel    = r_j ? r_nx : r_ny;
    assign n_mag   = nsel[N_W-1] ? N_W'(-nsel) : N_W'(nsel);
    assign den_mag = r_den[N_W-1] ? N_W'(-r_den) : N_W'(r_den);

    assign rem_sh = {r_rem, r_quo[DV_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    assign q_sat = (r_quo >= DV_W'(Q_SAT)) ? Q_SAT : r_quo[Q_W-1:0];
    assign q_val = r_neg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});

    always_comb begin
        base_y  = $signed({1'b0, r_byc}) - $signed({2'b00, r_hw});
        base_x  = $signed({1'b0, r_bx})  - $signed({2'b00, r_hw});
        sum_y   = (SUM_W'(base_y) <<< 8) + SUM_W'(r_qy);
        sum_x   = (SUM_W'(base_x) <<< 8) + SUM_W'(r_qx);
        lim_off = $signed(SUM_W'({r_hw, 8'b0}));
        if (sum_y > lim_off) begin
            cl_y = lim_off;
        end else if (sum_y < -lim_off) begin
            cl_y = -lim_off;
        end else begin
            cl_y = sum_y;
        end
        if (sum_x > lim_off) begin
            cl_x = lim_off;
        end else if (sum_x < -lim_off) begin
            cl_x = -lim_off;
        end else begin
            cl_x = sum_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                F_IDLE: begin
                    if (i_start) begin
                        r_rem_idx <= i_best_index;
                        r_by      <= '0;
                        r_hw      <= i_hw;
                        r_state   <= F_POS;
                    end
                end
                F_POS: begin
                    // Row and column of the peak by repeated subtraction.
                    if (r_rem_idx >= POS_W'(w)) begin
                        r_rem_idx <= r_rem_idx - POS_W'(w);
                        r_by      <= r_by + POS_W'(1);
                    end else begin
                        r_byc   <= (r_by > POS_W'(lim2)) ? lim2 : r_by[HW_W:0];
                        r_bx    <= r_rem_idx[HW_W:0];
                        r_k     <= '0;
                        r_m     <= '0;
                        r_state <= F_RD;
                    end
                end
                F_RD: begin
                    // Read data arrives in the cycle after its address.
                    if (r_k == 4'd1) begin
                        r_c0 <= i_rdata;
                    end else if (r_k >= 4'd2) begin
                        r_d[km2[2:0]] <= dnew;
                        if (dnew_mag > r_m) begin
                            r_m <= dnew_mag;
                        end
                    end
                    if (r_k == 4'd9) begin
                        r_s     <= '0;
                        r_state <= F_NORM;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                F_NORM: begin
                    if (r_m[D_W-1:FIT_BITS] != '0) begin
                        r_m <= r_m >> 1;
                        r_s <= r_s + S_W'(1);
                    end else begin
                        r_i     <= '0;
                        r_state <= F_SCL;
                    end
                end
                F_SCL: begin
                    r_ds[r_i] <= dsel[D_W-1] ? -$signed(SD_W'(dsel_sh))
                                             : $signed(SD_W'(dsel_sh));
                    if (r_i == 3'd7) begin
                        r_k     <= '0;
                        r_state <= F_MUL;
                    end else begin
                        r_i <= r_i + 3'd1;
                    end
                end
                F_MUL: begin
                    r_p[r_k[2:0]] <= mp;
                    if (r_k == 4'd5) begin
                        r_state <= F_NUM;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                F_NUM: begin
                    r_den   <= (N_W'(r_p[0]) <<< 4) - N_W'(r_p[1]);
                    r_ny    <= (N_W'(r_p[3]) <<< 1) - (N_W'(r_p[2]) <<< 3);
                    r_nx    <= (N_W'(r_p[5]) <<< 1) - (N_W'(r_p[4]) <<< 3);
                    r_j     <= 1'b0;
                    r_state <= F_DSET;
                end
                F_DSET: begin
                    if (r_den == '0) begin
                        // Flat fit: no sub-pixel shift.
                        if (r_j) begin
                            r_qx    <= '0;
                            r_state <= F_OFF;
                        end else begin
                            r_qy <= '0;
                            r_j  <= 1'b1;
                        end
                    end else begin
                        // Rounded quotient: (2*256*|n| + |den|) / (2*|den|).
                        r_quo   <= (DV_W'(n_mag) << 9) + DV_W'(den_mag);
                        r_dvs   <= DS_W'(den_mag) << 1;
                        r_rem   <= '0;
                        r_it    <= '0;
                        r_neg   <= nsel[N_W-1] != r_den[N_W-1];
                        r_state <= F_DIV;
                    end
                end
                F_DIV: begin
                    r_rem <= ge ? DS_W'(rem_sh - {1'b0, r_dvs}) : DS_W'(rem_sh);
                    r_quo <= {r_quo[DV_W-2:0], ge};
                    if (r_it == IT_W'(DV_W - 1)) begin
                        r_state <= F_DFIN;
                    end else begin
                        r_it <= r_it + IT_W'(1);
                    end
                end
                F_DFIN: begin
                    if (r_j) begin
                        r_qx    <= q_val;
                        r_state <= F_OFF;
                    end else begin
                        r_qy    <= q_val;
                        r_j     <= 1'b1;
                        r_state <= F_DSET;
                    end
                end
                F_OFF: begin
                    r_off_y <= cl_y[OFF_W-1:0];
                    r_off_x <= cl_x[OFF_W-1:0];
                    r_done  <= 1'b1;
                    r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_res.done  = r_done;
    assign o_res.off_y = r_off_y;
    assign o_res.off_x = r_off_x;

endmodule
`default_nettype wire

>>> rtl/core/block_match_ssd_subpixel_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_match_ssd_subpixel_unit
// Block-matching displacement search: negative SSD per window position,
// first strict maximum, and a quadratic sub-pixel fit around the peak.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake               Contents
// cfg       in   i_cfg_valid/o_cfg_ready index 0 half_window, 1 coeff_count
// s (in)    in   i_s_tvalid/o_s_tready   sample, est_dy, est_dx; tuser cmd;
//                                        tlast last
// m (out)   out  o_m_tvalid/i_m_tready   disp_y, disp_x, peak_score
//
// A pixel coefficient is stored on acceptance. A reference coefficient goes
// through pixel memory read, squaring on the multiplier, then accumulate and
// store, and no new request is taken until it is done. The request carrying
// last starts the peak fit: peak row search, neighbor reads, normalizing, the
// shared multiplier and the bit-serial divider.
// Reset is synchronous; both memories are left uncleared. A stalled result
// waits in the output register; new requests are taken meanwhile until the
// next fit result is ready to be loaded.
// ----------------------------------------------------------------------------
module block_match_ssd_subpixel_unit
    import bmss_pkg::*;
#(
    parameter int MAX_DEPTH       = DEF_MAX_DEPTH,
    parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [8:0]           i_cfg_data,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // [15:0] sample, [23:16] est_dy, [31:24] est_dx
    input  wire logic [31:0]          i_s_tdata,
    // [0] cmd
    input  wire logic                 i_s_tuser,
    input  wire logic                 i_s_tlast,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // [16:0] disp_y, [33:17] disp_x, [74:34] peak_score, [79:75] zero
    output logic [79:0]               o_m_tdata
);

    localparam int AW         = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W      = $clog2(MAX_DEPTH + 1);
    localparam int CW         = (CNT_W > 9) ? CNT_W : 9;
    localparam int HW_W       = $clog2(MAX_HALF_WINDOW + 1);
    localparam int HC_W       = (HW_W > 4) ? HW_W : 4;
    localparam int SIDE       = 2 * MAX_HALF_WINDOW + 1;
    localparam int STORE_SIZE = SIDE * SIDE;
    localparam int SA_W       = $clog2(STORE_SIZE);
    localparam int POS_W      = $clog2(STORE_SIZE + 1);
    localparam int WW_W       = 2 * (HW_W + 1);
    localparam int PC_W       = (POS_W > WW_W) ? POS_W : WW_W;
    localparam int SQ_W       = 2 * SAMPLE_BITS;
    localparam int ACC_W      = ((SQ_W > SSD_W) ? SQ_W : SSD_W) + 1;
    localparam int EXT_W      = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MAC  = 5'b00010,
        S_ACC  = 5'b00100,
        S_FIT  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state;
    logic [3:0]                r_hw;
    logic [8:0]                r_cc;
    logic [CNT_W-1:0]          r_cnt;
    logic [SSD_W-1:0]          r_acc;
    logic signed [SCORE_W-1:0] r_best;
    logic [POS_W-1:0]          r_best_idx;
    logic [POS_W-1:0]          r_pos;
    logic signed [7:0]         r_est_dy, r_est_dx;
    logic [SAMPLE_BITS-1:0]    r_smp;
    logic                      r_last;
    logic                      r_pos_done;
    logic [SQ_W-1:0]           r_sq;
    logic                      r_fit_start;
    logic                      r_ovalid;
    logic [79:0]               r_odata;

    logic                      s_acc;
    logic [HC_W-1:0]           hw_z;
    logic [HW_W-1:0]           eff_hw;
    logic [CW-1:0]             cc_z, eff_cnt;
    logic [AW-1:0]             idx;
    logic [CW-1:0]             nxt;
    logic                      wrap;
    logic [EXT_W-1:0]          smp_ext;
    logic [SAMPLE_BITS-1:0]    smp;
    logic [SAMPLE_BITS-1:0]    pix;
    logic signed [SAMPLE_BITS:0]     diff;
    logic signed [2*SAMPLE_BITS+1:0] prod;
    logic [ACC_W-1:0]          sum;
    logic [SSD_W-1:0]          acc_new;
    logic signed [SCORE_W-1:0] score;
    logic [HW_W:0]             w;
    logic [WW_W-1:0]           wsq;
    logic                      pos_in;
    logic                      st_we;
    logic [SA_W-1:0]           fit_raddr;
    logic signed [SCORE_W-1:0] st_rdata;
    t_fit_res                  fit_res;
    logic                      load_out;
    logic signed [DISP_W-1:0]  disp_y, disp_x;
    logic signed [SCORE_W-1:0] peak;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;

    assign hw_z    = HC_W'(r_hw);
    assign eff_hw  = (hw_z > HC_W'(MAX_HALF_WINDOW)) ? HW_W'(MAX_HALF_WINDOW)
                                                    : HW_W'(hw_z);
    assign cc_z    = CW'(r_cc);
    assign eff_cnt = (cc_z == '0) ? CW'(1)
                   : (cc_z > CW'(MAX_DEPTH)) ? CW'(MAX_DEPTH) : cc_z;
    assign idx     = (r_cnt < CNT_W'(MAX_DEPTH)) ? r_cnt[AW-1:0] : AW'(MAX_DEPTH - 1);
    assign nxt     = CW'(idx) + CW'(1);
    assign wrap    = nxt >= eff_cnt;

    assign smp_ext = EXT_W'(i_s_tdata[15:0]);
    assign smp     = smp_ext[SAMPLE_BITS-1:0];

    assign diff = $signed({r_smp[SAMPLE_BITS-1], r_smp}) - $signed({pix[SAMPLE_BITS-1], pix});
    assign prod = diff * diff;

    assign sum     = ACC_W'(r_acc) + ACC_W'(r_sq);
    assign acc_new = (sum > ACC_W'(SSD_LIMIT)) ? SSD_LIMIT : sum[SSD_W-1:0];
    assign score   = -$signed(SCORE_W'(acc_new));

    assign w      = {eff_hw, 1'b1};
    assign wsq    = w * w;
    assign pos_in = PC_W'(r_pos) < PC_W'(wsq);
    assign st_we  = (r_state == S_ACC) && r_pos_done && pos_in;

    assign load_out = (r_state == S_OUT) && (!r_ovalid || i_m_tready);

    assign disp_y = DISP_W'(fit_res.off_y) + $signed({r_est_dy, 8'b0});
    assign disp_x = DISP_W'(fit_res.off_x) + $signed({r_est_dx, 8'b0});
    assign peak   = (r_best < -$signed(SCORE_W'(SSD_LIMIT))) ? -$signed(SCORE_W'(SSD_LIMIT))
                                                            : r_best;

    bmss_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_DEPTH)
    ) u_pixel_ram (
        .i_clk   (i_clk),
        .i_we    (s_acc && (i_s_tuser == CMD_PIXEL)),
        .i_waddr (idx),
        .i_wdata (smp),
        .i_raddr (idx),
        .o_rdata (pix)
    );

    bmss_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (STORE_SIZE)
    ) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_pos[SA_W-1:0]),
        .i_wdata (score),
        .i_raddr (fit_raddr),
        .o_rdata (st_rdata)
    );

    bmss_fit #(
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
    ) u_fit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_fit_start),
        .i_best_index (r_best_idx),
        .i_hw         (eff_hw),
        .o_raddr      (fit_raddr),
        .i_rdata      (st_rdata),
        .o_res        (fit_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hw        <= HALF_WINDOW_RESET;
            r_cc        <= COEFF_COUNT_RESET;
            r_cnt       <= '0;
            r_acc       <= '0;
            r_best      <= {1'b1, {(SCORE_W-1){1'b0}}};
            r_best_idx  <= '0;
            r_pos       <= '0;
            r_est_dy    <= '0;
            r_est_dx    <= '0;
            r_fit_start <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_fit_start <= 1'b0;
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_HALF_WINDOW) begin
                    r_hw <= i_cfg_data[3:0];
                end else if (i_cfg_index == REG_COEFF_COUNT) begin
                    r_cc <= i_cfg_data;
                end
            end
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        if (i_s_tuser == CMD_PIXEL) begin
                            // First coefficient of a new pixel opens a new search.
                            if (r_cnt == '0) begin
                                r_acc      <= '0;
                                r_best     <= {1'b1, {(SCORE_W-1){1'b0}}};
                                r_best_idx <= '0;
                                r_pos      <= '0;
                                r_est_dy   <= $signed(i_s_tdata[23:16]);
                                r_est_dx   <= $signed(i_s_tdata[31:24]);
                            end
                            r_cnt <= wrap ? '0 : CNT_W'(nxt);
                        end else begin
                            r_smp      <= smp;
                            r_last     <= i_s_tlast;
                            r_pos_done <= wrap || i_s_tlast;
                            r_cnt      <= (wrap || i_s_tlast) ? '0 : CNT_W'(nxt);
                            r_state    <= S_MAC;
                        end
                    end
                end
                S_MAC: begin
                    r_sq    <= prod[SQ_W-1:0];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_pos_done) begin
                        r_acc <= '0;
                        if (pos_in) begin
                            if (score > r_best) begin
                                r_best     <= score;
                                r_best_idx <= r_pos;
                            end
                            r_pos <= r_pos + POS_W'(1);
                        end
                    end else begin
                        r_acc <= acc_new;
                    end
                    if (r_last) begin
                        r_fit_start <= 1'b1;
                        r_state     <= S_FIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_FIT: begin
                    if (fit_res.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (load_out) begin
                        r_odata    <= {5'b0, peak[PEAK_W-1:0], disp_x, disp_y};
                        r_ovalid   <= 1'b1;
                        r_acc      <= '0;
                        r_best     <= {1'b1, {(SCORE_W-1){1'b0}}};
                        r_best_idx <= '0;
                        r_pos      <= '0;
                        r_cnt      <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    // The fit reports only while the search waits for it.
    a_fit_done_in_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fit_res.done |-> (r_state == S_FIT))
        else $error("fit result outside of fit phase");

    // No request is taken while the fit runs.
    a_no_req_in_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIT) |-> !o_s_tready)
        else $error("request accepted during fit");

    // A new result is loaded only from the output state.
    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_OUT))
        else $error("result loaded outside output state");

    // The accumulator never passes its saturation limit.
    a_acc_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= SSD_LIMIT)
        else $error("SSD accumulator above limit");

endmodule
`default_nettype wire

>>> dv/block_match_ssd_subpixel_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_match_ssd_subpixel_unit_tb
// Self-checking bench for the block-matching SSD search. Feature and reference
// coefficients stream in with random bursts and gaps. The output side stalls
// at random and at times holds off for a long stretch. A behavioral copy of the
// search and the quadratic peak fit predicts every displacement and peak
// score. A few directed requests carry expected values written out by hand.
// ----------------------------------------------------------------------------
module block_match_ssd_subpixel_unit_tb;
    import bmss_pkg::*;

    localparam int DEPTH     = DEF_MAX_DEPTH;
    localparam int SIDE      = 2 * DEF_MAX_HALF_WINDOW + 1;
    localparam int IDLE_WAIT = 300;
    localparam int WDOG_MAX  = 20000;
    localparam longint SSD_MAX  = 64'sd1 << 40;
    localparam longint BEST_CLR = -(64'sd1 << 41);
    localparam longint FIT_MAX  = 64'sd1 << 22;

    typedef struct {
        logic [DISP_W-1:0] disp_y;
        logic [DISP_W-1:0] disp_x;
        logic [PEAK_W-1:0] peak;
    } disp_t;

    typedef struct {
        logic        cmd;
        logic [15:0] sample;
        logic [7:0]  dy;
        logic [7:0]  dx;
        logic        last;
        bit          typed;
        disp_t       res;
    } row_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [8:0]         i_cfg_data;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [31:0]        i_s_tdata;
    logic               i_s_tuser;
    logic               i_s_tlast;
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [79:0]        o_m_tdata;

    block_match_ssd_subpixel_unit u_top (.*);

    // Predictor state.
    logic signed [15:0] pix_mem [DEPTH];
    longint             score_mem [SIDE*SIDE];
    longint             ssd_acc;
    longint             best_sc;
    int                 best_idx;
    int                 coeff_cnt;
    int                 pos_cnt;
    int                 held_dy;
    int                 held_dx;
    int                 hw_reg;
    int                 cnt_reg;

    disp_t              disp_q [$];
    int                 err_cnt;
    int                 idle_cyc;
    int                 rand_items;
    bit                 hold_req;
    int                 burst_left;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint peek(longint r, longint c, longint w);
        if (r < 0) r = 0;
        if (r > w - 1) r = w - 1;
        if (c < 0) c = 0;
        if (c > w - 1) c = w - 1;
        return score_mem[r * w + c];
    endfunction

    function automatic longint q8_quot(longint num, longint den);
        longint unsigned a, b, q;
        if (den == 0) return 0;
        a = longint'(mag(num)) * 256;
        b = mag(den);
        q = (2 * a + b) / (2 * b);
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp_off(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic void clear_search();
        ssd_acc   = 0;
        best_sc   = BEST_CLR;
        best_idx  = 0;
        pos_cnt   = 0;
        coeff_cnt = 0;
    endfunction

    // Quadratic fit over the 3x3 neighborhood of the best position.
    function automatic void fit_peak(output longint py, output longint px);
        longint hw, w, by, bx, c0, m, gy, gx, dyy, dxx, dd, den, ny, nx;
        longint d [8];
        int s;
        hw = hw_reg;
        w  = 2 * hw + 1;
        by = best_idx / w;
        bx = best_idx % w;
        m  = 0;
        s  = 0;
        if (by > w - 1) by = w - 1;
        c0 = peek(by, bx, w);
        d[0] = peek(by - 1, bx, w) - c0;
        d[1] = peek(by + 1, bx, w) - c0;
        d[2] = peek(by, bx - 1, w) - c0;
        d[3] = peek(by, bx + 1, w) - c0;
        d[4] = peek(by + 1, bx + 1, w) - c0;
        d[5] = peek(by + 1, bx - 1, w) - c0;
        d[6] = peek(by - 1, bx + 1, w) - c0;
        d[7] = peek(by - 1, bx - 1, w) - c0;
        foreach (d[i]) if (mag(d[i]) > m) m = mag(d[i]);
        while ((m >> s) >= FIT_MAX) s++;
        foreach (d[i]) d[i] = d[i] < 0 ? -(mag(d[i]) >> s) : (d[i] >> s);
        gy  = d[1] - d[0];
        dyy = d[1] + d[0];
        gx  = d[3] - d[2];
        dxx = d[3] + d[2];
        dd  = d[4] - d[5] - d[6] + d[7];
        den = 16 * dxx * dyy - dd * dd;
        ny  = -(8 * dxx * gy - 2 * dd * gx);
        nx  = -(8 * dyy * gx - 2 * dd * gy);
        py = clamp_off((by - hw) * 256 + q8_quot(ny, den), hw * 256);
        px = clamp_off((bx - hw) * 256 + q8_quot(nx, den), hw * 256);
    endfunction

    // Advances the predictor by one request; returns 1 when a result is due.
    function automatic bit predict_disp(logic cmd, logic [15:0] smp_bits, logic [7:0] dy,
                                        logic [7:0] dx, logic last, output disp_t res);
        int cnt, idx, w;
        longint smp, diff, score, py, px, pk;
        cnt = cnt_reg == 0 ? 1 : (cnt_reg > DEPTH ? DEPTH : cnt_reg);
        idx = coeff_cnt < DEPTH ? coeff_cnt : DEPTH - 1;
        smp = longint'($signed(smp_bits));
        res = '{default: '0};
        if (cmd == CMD_PIXEL) begin
            if (coeff_cnt == 0) begin
                clear_search();
                held_dy = int'($signed(dy));
                held_dx = int'($signed(dx));
            end
            pix_mem[idx] = smp_bits;
            coeff_cnt = idx + 1;
            if (coeff_cnt >= cnt) coeff_cnt = 0;
            return 1'b0;
        end
        diff = smp - longint'(pix_mem[idx]);
        ssd_acc += diff * diff;
        if (ssd_acc > SSD_MAX) ssd_acc = SSD_MAX;
        coeff_cnt = idx + 1;
        if (coeff_cnt >= cnt || last) begin
            w = 2 * hw_reg + 1;
            score = -ssd_acc;
            if (pos_cnt < w * w) begin
                score_mem[pos_cnt] = score;
                if (score > best_sc) begin
                    best_sc  = score;
                    best_idx = pos_cnt;
                end
                pos_cnt++;
            end
            ssd_acc   = 0;
            coeff_cnt = 0;
        end
        if (!last) return 1'b0;
        fit_peak(py, px);
        pk = best_sc < -SSD_MAX ? -SSD_MAX : best_sc;
        res.disp_y = DISP_W'(py + longint'(held_dy) * 256);
        res.disp_x = DISP_W'(px + longint'(held_dx) * 256);
        res.peak   = PEAK_W'(pk);
        clear_search();
        return 1'b1;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    task automatic send_req(logic cmd, logic [15:0] smp, logic [7:0] dy, logic [7:0] dx,
                            logic last, bit typed = 0, disp_t typed_res = '{default: '0});
        int gap;
        disp_t res;
        bit due;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tlast  <= last;
        i_s_tdata  <= {dx, dy, smp};
        do @(posedge i_clk); while (!o_s_tready);
        due = predict_disp(cmd, smp, dy, dx, last, res);
        if (typed) disp_q.push_back(typed_res);
        else if (due) disp_q.push_back(res);
        @(negedge i_clk);
    endtask

    // Lets the block drain before a register write.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (disp_q.size() != 0) @(negedge i_clk);
        repeat (IDLE_WAIT) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [8:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_HALF_WINDOW) hw_reg = int'(val[3:0]);
        else if (idx == REG_COEFF_COUNT) cnt_reg = int'(val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(int hw, int cnt);
        drain();
        cfg_write(REG_HALF_WINDOW, 9'(hw));
        cfg_write(REG_COEFF_COUNT, 9'(cnt));
    endtask

    function automatic logic [15:0] pick_sample(logic [15:0] base, int spread);
        int v;
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom);
            default: begin
                v = int'($signed(base)) + $urandom_range(0, 2 * spread) - spread;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                return 16'(v);
            end
        endcase
    endfunction

    // One pixel: feature vector, then the reference vectors of the window.
    // A broken pixel ends early or mixes in stray feature coefficients.
    task automatic run_pixel(bit broken);
        logic [15:0] feat [DEPTH];
        logic [7:0] dy, dx;
        int cnt, w2, total, stop, target, spread, k;
        cnt = cnt_reg == 0 ? 1 : cnt_reg;
        w2 = (2 * hw_reg + 1) * (2 * hw_reg + 1);
        total = w2 * cnt;
        stop = broken ? $urandom_range(1, total) : total;
        target = $urandom_range(0, w2 - 1);
        dy = 8'($urandom);
        dx = 8'($urandom);
        for (int i = 0; i < cnt; i++) begin
            feat[i] = 16'($urandom);
            send_req(CMD_PIXEL, feat[i], dy, dx, 1'($urandom));
            rand_items++;
        end
        for (int i = 0; i < stop; i++) begin
            k = i / cnt;
            spread = 4 + 64 * (k > target ? k - target : target - k);
            if (broken && $urandom_range(0, 30) == 0) begin
                send_req(CMD_PIXEL, 16'($urandom), 8'($urandom), 8'($urandom), 1'b0);
                rand_items++;
            end
            send_req(CMD_REF, pick_sample(feat[i % cnt], spread), 8'($urandom),
                     8'($urandom), (i == stop - 1));
            rand_items++;
        end
    endtask

    // Checks each result against the oldest expectation.
    always @(posedge i_clk) begin
        disp_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (disp_q.size() == 0) begin
                $error("result with no expectation: %h", o_m_tdata);
                err_cnt++;
            end else begin
                want = disp_q.pop_front();
                if (o_m_tdata[16:0] !== want.disp_y) begin
                    $error("disp_y: expected %h, got %h", want.disp_y, o_m_tdata[16:0]);
                    err_cnt++;
                end
                if (o_m_tdata[33:17] !== want.disp_x) begin
                    $error("disp_x: expected %h, got %h", want.disp_x, o_m_tdata[33:17]);
                    err_cnt++;
                end
                if (o_m_tdata[74:34] !== want.peak) begin
                    $error("peak_score: expected %h, got %h", want.peak, o_m_tdata[74:34]);
                    err_cnt++;
                end
                if (o_m_tdata[79:75] !== 5'd0) begin
                    $error("pad: expected 0, got %h", o_m_tdata[79:75]);
                    err_cnt++;
                end
            end
        end
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WDOG_MAX) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stalls, stretches of steady ready, long hold-offs on request.
    initial begin
        int hold_left, steady_left;
        hold_left = 0;
        steady_left = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (steady_left > 0) begin
                steady_left--;
                i_m_tready <= 1'b1;
            end else begin
                if ($urandom_range(0, 40) == 0) steady_left = $urandom_range(20, 200);
                i_m_tready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    initial begin
        row_t rows [$];
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = CMD_PIXEL;
        i_s_tlast   = 1'b0;
        err_cnt     = 0;
        idle_cyc    = 0;
        rand_items  = 0;
        hold_req    = 0;
        burst_left  = 0;
        hw_reg      = int'(HALF_WINDOW_RESET);
        cnt_reg     = int'(COEFF_COUNT_RESET);
        held_dy     = 0;
        held_dx     = 0;
        clear_search();
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part on a single-position window, one coefficient each.
        set_mode(0, 1);
        rows = '{
            '{CMD_PIXEL, 16'h0000, 8'h7f, 8'h80, 1'b0, 0, '{default: '0}},
            '{CMD_REF,   16'h8000, 8'h00, 8'h00, 1'b1, 1,
              '{17'd32512, 17'h18000, PEAK_W'(-(64'sd1 << 30))}},
            '{CMD_PIXEL, 16'h7fff, 8'h80, 8'h7f, 1'b0, 0, '{default: '0}},
            '{CMD_REF,   16'h7fff, 8'hff, 8'hff, 1'b1, 1,
              '{17'h18000, 17'd32512, 41'd0}},
            // Last on a feature coefficient is ignored.
            '{CMD_PIXEL, 16'h0003, 8'h01, 8'hff, 1'b1, 0, '{default: '0}},
            '{CMD_REF,   16'h0005, 8'h00, 8'h00, 1'b0, 0, '{default: '0}},
            // A position beyond the window is neither stored nor compared.
            '{CMD_REF,   16'h0003, 8'h00, 8'h00, 1'b1, 0, '{default: '0}},
            // A window with no fresh feature vector reuses the stored one.
            '{CMD_REF,   16'hfff0, 8'h00, 8'h00, 1'b1, 0, '{default: '0}},
            '{CMD_PIXEL, 16'h5555, 8'haa, 8'h55, 1'b0, 0, '{default: '0}},
            '{CMD_REF,   16'haaaa, 8'h00, 8'h00, 1'b1, 0, '{default: '0}}
        };
        foreach (rows[i])
            send_req(rows[i].cmd, rows[i].sample, rows[i].dy, rows[i].dx, rows[i].last,
                     rows[i].typed, rows[i].res);

        // Full-depth vector with opposite extremes brings the SSD just under its limit,
        // and a full widest window afterwards leaves every score entry written.
        set_mode(0, 256);
        for (int i = 0; i < 256; i++) send_req(CMD_PIXEL, 16'h8000, 8'h12, 8'hed, 1'b0);
        for (int i = 0; i < 256; i++) send_req(CMD_REF, 16'h7fff, 8'h00, 8'h00, (i == 255));
        set_mode(15, 0);
        send_req(CMD_PIXEL, 16'h1234, 8'hf0, 8'h0f, 1'b0);
        for (int i = 0; i < 961; i++)
            send_req(CMD_REF, pick_sample(16'h1234, 8 + 40 * (i % 31)), 8'h00, 8'h00,
                     (i == 960));

        // Random part.
        while (rand_items < 600) begin
            case ($urandom_range(0, 9))
                0: set_mode(15, $urandom_range(0, 1));
                1: set_mode($urandom_range(0, 1), $urandom_range(64, 256));
                default: set_mode($urandom_range(0, 3), $urandom_range(1, 4));
            endcase
            if (rand_items > 200 && rand_items < 260) hold_req = 1;
            repeat ($urandom_range(2, 5)) run_pixel($urandom_range(0, 4) == 0);
        end
        set_mode(2, 9'h1ff);
        repeat (2) run_pixel(1'b0);

        i_s_tvalid <= 1'b0;
        while (disp_q.size() != 0) @(negedge i_clk);
        repeat (IDLE_WAIT) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire
